[design/mmpwc_pkg.sv]
// shared constants, types and helpers for the closed-walk matrix power block
// no dependencies; used by mmpwc_ram, mmpwc_modmac and the top level
package mmpwc_pkg;

  // default exponent width
  localparam int EXP_BITS = 31;

  // matrix geometry
  localparam int DIM_W  = 2;
  localparam int BANK_W = 2;
  localparam int ADDR_W = BANK_W + 2 * DIM_W;
  localparam int RES_W  = 30;
  localparam int OUT_W  = 32;

  // modulus and barrett reciprocal floor(2^60 / prime)
  localparam logic [29:0] PRIME      = 30'd1000000007;
  localparam logic [30:0] PRIME2     = 31'd2000000014;
  localparam logic [30:0] BARRETT_MU = 31'((64'd1 << 60) / 64'(PRIME));

  // tag that travels with one multiply-accumulate through the pipe
  typedef struct packed {
    logic              v;
    logic              first;
    logic              last;
    logic [ADDR_W-1:0] waddr;
  } mac_tag_t;

  // entry of the identity (is_id) or the adjacency matrix
  function automatic logic [RES_W-1:0] mat_const(input logic is_id,
                                                 input logic [DIM_W-1:0] r,
                                                 input logic [DIM_W-1:0] c);
    logic hit;
    hit = is_id ? (r == c) : (r != c);
    return hit ? RES_W'(1) : RES_W'(0);
  endfunction

endpackage

[design/mmpwc_ram.sv]
// matrix store: four 4x4 banks of residues, one write port, two registered reads
// depends on mmpwc_pkg for widths
module mmpwc_ram (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [mmpwc_pkg::ADDR_W-1:0] wr_addr,
  input  logic [mmpwc_pkg::RES_W-1:0]  wr_data,
  input  logic [mmpwc_pkg::ADDR_W-1:0] rd_a_addr,
  input  logic [mmpwc_pkg::ADDR_W-1:0] rd_b_addr,
  output logic [mmpwc_pkg::RES_W-1:0]  rd_a_data,
  output logic [mmpwc_pkg::RES_W-1:0]  rd_b_data
);

  logic [mmpwc_pkg::RES_W-1:0] mem [1 << mmpwc_pkg::ADDR_W];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read ports
  always_ff @(posedge clk) begin
    rd_a_data <= mem[rd_a_addr];
    rd_b_data <= mem[rd_b_addr];
  end

endmodule

[design/mmpwc_modmac.sv]
// shared modular multiply-accumulate pipe: product, barrett reduction, mod add
// depends on mmpwc_pkg for the modulus, reciprocal and tag type
module mmpwc_modmac (
  input  logic                         clk,
  input  logic                         rst_n,
  input  mmpwc_pkg::mac_tag_t          tag_i,
  input  logic [mmpwc_pkg::RES_W-1:0]  a_i,
  input  logic [mmpwc_pkg::RES_W-1:0]  b_i,
  output logic                         wr_en_o,
  output logic [mmpwc_pkg::ADDR_W-1:0] wr_addr_o,
  output logic [mmpwc_pkg::RES_W-1:0]  wr_data_o,
  output logic                         busy_o
);

  mmpwc_pkg::mac_tag_t tag1_r, tag2_r, tag3_r, tag4_r, tag5_r;

  logic [59:0] prod_r;
  logic [61:0] qm;
  logic [30:0] q_r;
  logic [31:0] lo2_r, lo3_r;
  logic [60:0] qp;
  logic [31:0] qp_r;
  logic [31:0] diff;
  logic [29:0] res_nxt, res_r;
  logic [29:0] acc_base;
  logic [30:0] sum;
  logic [29:0] acc_nxt, acc_r;

  // tag pipe, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
      tag2_r <= '0;
      tag3_r <= '0;
      tag4_r <= '0;
      tag5_r <= '0;
    end else begin
      tag1_r <= tag_i;
      tag2_r <= tag1_r;
      tag3_r <= tag2_r;
      tag4_r <= tag3_r;
      tag5_r <= tag4_r;
    end
  end

  // quotient estimate and its multiple of the prime
  assign qm = 62'(prod_r[59:29]) * 62'(mmpwc_pkg::BARRETT_MU);
  assign qp = 61'(q_r) * 61'(mmpwc_pkg::PRIME);

  // remainder below three primes, brought into range
  assign diff = lo3_r - qp_r;
  always_comb begin
    if (diff >= {1'b0, mmpwc_pkg::PRIME2}) begin
      res_nxt = 30'(diff - {1'b0, mmpwc_pkg::PRIME2});
    end else if (diff >= {2'b00, mmpwc_pkg::PRIME}) begin
      res_nxt = 30'(diff - {2'b00, mmpwc_pkg::PRIME});
    end else begin
      res_nxt = diff[29:0];
    end
  end

  // conditional-subtract modular add into the running dot product
  assign acc_base = tag4_r.first ? 30'd0 : acc_r;
  assign sum      = {1'b0, acc_base} + {1'b0, res_r};
  assign acc_nxt  = (sum >= {1'b0, mmpwc_pkg::PRIME}) ? 30'(sum - {1'b0, mmpwc_pkg::PRIME})
                                                     : sum[29:0];

  // datapath stages
  always_ff @(posedge clk) begin
    prod_r <= 60'(a_i) * 60'(b_i);
    q_r    <= qm[61:31];
    lo2_r  <= prod_r[31:0];
    qp_r   <= qp[31:0];
    lo3_r  <= lo2_r;
    res_r  <= res_nxt;
    if (tag4_r.v) begin
      acc_r <= acc_nxt;
    end
  end

  assign wr_en_o   = tag5_r.v & tag5_r.last;
  assign wr_addr_o = tag5_r.waddr;
  assign wr_data_o = acc_r;
  assign busy_o    = tag_i.v | tag1_r.v | tag2_r.v | tag3_r.v | tag4_r.v | tag5_r.v;

endmodule

[design/modular_matrix_power_walk_count.sv]
// top level: sequencer for square-and-multiply of the 4x4 walk matrix mod 1e9+7
// depends on mmpwc_pkg, mmpwc_ram and mmpwc_modmac
//
// usage: a word on the in_ channel carries the exponent n; the block answers with
// one word on the out_ channel holding the top-left entry of M^n mod 1000000007,
// the number of closed walks of length n on the complete graph of four vertices.
// in_tready is high only while the sequencer is idle; one word is in work at a time.
// the exponent is scanned lowest bit first; each set bit costs one product
// acc*base and each bit below the highest set bit costs one squaring base*base.
// every 4x4 product issues 64 multiply-accumulates, one per cycle, into the single
// shared modmac pipe, then waits in the drain state until the pipe is empty and
// goes to the step state, which starts the next product or ends the run;
// n = 0 starts no product and goes from the step state to the result read.
// product results go to the free bank of the matrix store and banks swap roles,
// so no copy pass is needed. the result sits in an output register: a stalled
// receiver holds it there, the next word is still accepted, and the sequencer
// waits at its end until the register is free. reset (rst_n low, synchronous)
// returns to idle and drops any pending result; the store needs no clearing.
module modular_matrix_power_walk_count #(
  parameter int EXP_BITS = mmpwc_pkg::EXP_BITS,
  localparam int IN_W = ((EXP_BITS + 7) / 8) * 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [IN_W-1:0]             in_tdata,   // [EXP_BITS-1:0] exponent
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [mmpwc_pkg::OUT_W-1:0] out_tdata   // [29:0] walk_count
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_STEP  = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_RES   = 3'd4;
  localparam logic [2:0] S_RD    = 3'd5;

  localparam int DW = mmpwc_pkg::DIM_W;
  localparam int BW = mmpwc_pkg::BANK_W;
  localparam int AW = mmpwc_pkg::ADDR_W;
  localparam int RW = mmpwc_pkg::RES_W;

  logic [2:0]          state_r, state_nxt;
  logic [EXP_BITS-1:0] e_r, e_nxt;
  logic [3*DW-1:0]     cnt_r, cnt_nxt;
  logic                kind_acc_r, kind_acc_nxt;
  logic                acc_id_r, acc_id_nxt;
  logic                base_m_r, base_m_nxt;
  logic [BW-1:0]       acc_bk_r, acc_bk_nxt;
  logic [BW-1:0]       base_bk_r, base_bk_nxt;
  logic [BW-1:0]       free_bk_r, free_bk_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [RW-1:0]       out_data_r, out_data_nxt;

  logic [DW-1:0]       ir, ic, ik;
  logic [BW-1:0]       src_a_bk;
  logic [AW-1:0]       rd_a_addr, rd_b_addr;
  logic [RW-1:0]       rd_a_data, rd_b_data;
  logic                issue;
  mmpwc_pkg::mac_tag_t tag_nxt, t0_r;
  logic                use_a_r, use_b_r;
  logic [RW-1:0]       ca_r, cb_r;
  logic [RW-1:0]       op_a, op_b;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [RW-1:0]       wr_data;
  logic                busy;
  logic                load_out;

  // issue indices: k innermost so one dot product runs in consecutive cycles
  assign ir = cnt_r[3*DW-1:2*DW];
  assign ic = cnt_r[2*DW-1:DW];
  assign ik = cnt_r[DW-1:0];

  assign src_a_bk  = kind_acc_r ? acc_bk_r : base_bk_r;
  assign issue     = (state_r == S_MUL);
  assign rd_a_addr = issue ? {src_a_bk, ir, ik} : {acc_bk_r, {(2 * DW){1'b0}}};
  assign rd_b_addr = {base_bk_r, ik, ic};

  always_comb begin
    tag_nxt.v     = issue;
    tag_nxt.first = (ik == '0);
    tag_nxt.last  = (ik == '1);
    tag_nxt.waddr = {free_bk_r, ir, ic};
  end

  // read-aligned tag and constant substitution for untouched matrices
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t0_r <= '0;
    end else begin
      t0_r <= tag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    use_a_r    <= kind_acc_r ? acc_id_r : base_m_r;
    use_b_r    <= base_m_r;
    ca_r       <= mmpwc_pkg::mat_const(kind_acc_r, ir, ik);
    cb_r       <= mmpwc_pkg::mat_const(1'b0, ik, ic);
  end

  assign op_a = use_a_r ? ca_r : rd_a_data;
  assign op_b = use_b_r ? cb_r : rd_b_data;

  // matrix store
  mmpwc_ram u_ram (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_a_addr (rd_a_addr),
    .rd_b_addr (rd_b_addr),
    .rd_a_data (rd_a_data),
    .rd_b_data (rd_b_data)
  );

  // shared multiply-accumulate unit
  mmpwc_modmac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .tag_i     (t0_r),
    .a_i       (op_a),
    .b_i       (op_b),
    .wr_en_o   (wr_en),
    .wr_addr_o (wr_addr),
    .wr_data_o (wr_data),
    .busy_o    (busy)
  );

  assign load_out = (state_r == S_RD) && (!out_valid_r || out_tready);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    e_nxt         = e_r;
    cnt_nxt       = cnt_r;
    kind_acc_nxt  = kind_acc_r;
    acc_id_nxt    = acc_id_r;
    base_m_nxt    = base_m_r;
    acc_bk_nxt    = acc_bk_r;
    base_bk_nxt   = base_bk_r;
    free_bk_nxt   = free_bk_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          e_nxt       = in_tdata[EXP_BITS-1:0];
          acc_id_nxt  = 1'b1;
          base_m_nxt  = 1'b1;
          acc_bk_nxt  = BW'(0);
          base_bk_nxt = BW'(1);
          free_bk_nxt = BW'(2);
          state_nxt   = S_STEP;
        end
      end
      S_STEP: begin
        if (e_r == '0) begin
          state_nxt = S_RES;
        end else begin
          kind_acc_nxt = e_r[0];
          cnt_nxt      = '0;
          state_nxt    = S_MUL;
        end
      end
      S_MUL: begin
        cnt_nxt = cnt_r + (3 * DW)'(1);
        if (cnt_r == '1) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!busy) begin
          free_bk_nxt = kind_acc_r ? acc_bk_r : base_bk_r;
          if (kind_acc_r) begin
            acc_bk_nxt = free_bk_r;
            acc_id_nxt = 1'b0;
            e_nxt      = e_r & ~(EXP_BITS'(1));
          end else begin
            base_bk_nxt = free_bk_r;
            base_m_nxt  = 1'b0;
            e_nxt       = e_r >> 1;
          end
          state_nxt = S_STEP;
        end
      end
      S_RES: begin
        state_nxt = S_RD;
      end
      S_RD: begin
        if (load_out) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = acc_id_r ? RW'(1) : rd_a_data;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    e_r        <= e_nxt;
    cnt_r      <= cnt_nxt;
    kind_acc_r <= kind_acc_nxt;
    acc_id_r   <= acc_id_nxt;
    base_m_r   <= base_m_nxt;
    acc_bk_r   <= acc_bk_nxt;
    base_bk_r  <= base_bk_nxt;
    free_bk_r  <= free_bk_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(mmpwc_pkg::OUT_W - RW){1'b0}}, out_data_r};

  // products never land in a bank that is still being read
  a_wr_free_bank: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (wr_addr[AW-1 -: BW] != acc_bk_r) && (wr_addr[AW-1 -: BW] != base_bk_r))
    else $error("matrix write hits a live bank");

  // bank roles stay distinct while a word is in work
  a_banks_distinct: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |->
      (acc_bk_r != base_bk_r) && (acc_bk_r != free_bk_r) && (base_bk_r != free_bk_r))
    else $error("bank roles collide");

  // the mac pipe is empty whenever a new word can be taken
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !busy)
    else $error("mac pipe busy while idle");

  // results are fully reduced
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_data_r < mmpwc_pkg::PRIME))
    else $error("walk count out of range");

endmodule

[bench/tb_top.sv]
// testbench for modular_matrix_power_walk_count: closed walks of length n on the
// complete four-vertex graph, (M^n)[0][0] mod 1e9+7, checked against a local predictor
// depends on mmpwc_pkg and the design sources; standalone, no files or arguments
`timescale 1ns / 100ps

module tb_top;

  localparam int EXP_BITS     = mmpwc_pkg::EXP_BITS;
  localparam int RES_W        = mmpwc_pkg::RES_W;
  localparam int OUT_W        = mmpwc_pkg::OUT_W;
  localparam int IN_W         = ((EXP_BITS + 7) / 8) * 8;
  localparam int LIMIT_CYCLES = 4_000_000;
  localparam int HOLD_CYCLES  = 12000;
  localparam int TAIL_CYCLES  = 200;
  localparam int RAND_ITEMS   = 120;

  typedef bit [0:3][0:3][RES_W-1:0] walk_mat_t;

  logic            clk        = 1'b0;
  logic            rst_n      = 1'b0;
  logic            in_tvalid  = 1'b0;
  logic            in_tready;
  logic [IN_W-1:0] in_tdata   = '0;
  logic            out_tvalid;
  logic            out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  // exponents waiting to be offered, walk counts waiting to come back
  bit [EXP_BITS-1:0] exponent_q[$];
  bit [RES_W-1:0]    walk_count_q[$];

  int send_idle_pct = 28;
  int recv_idle_pct = 51;
  int stim_phase    = 0;
  int fail_cnt      = 0;
  int cycle_cnt     = 0;
  int hold_left     = 0;
  bit hold_done     = 1'b0;

  modular_matrix_power_walk_count uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),     // [30:0] exponent
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)     // [29:0] walk_count
  );

  // clock, 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // product of two residue matrices mod the prime, summed with conditional subtract
  function automatic walk_mat_t residue_mat_mul(walk_mat_t a, walk_mat_t b);
    walk_mat_t        p;
    longint unsigned  term;
    longint unsigned  sum;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        sum = 0;
        for (int k = 0; k < 4; k++) begin
          term = (longint'(a[r][k]) * longint'(b[k][c])) % longint'(mmpwc_pkg::PRIME);
          sum  = sum + term;
          if (sum >= longint'(mmpwc_pkg::PRIME)) sum = sum - longint'(mmpwc_pkg::PRIME);
        end
        p[r][c] = sum[RES_W-1:0];
      end
    end
    return p;
  endfunction

  // square-and-multiply, lowest exponent bit first; n = 0 leaves the identity
  function automatic bit [RES_W-1:0] closed_walks(bit [EXP_BITS-1:0] n);
    walk_mat_t acc;
    walk_mat_t base;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        acc[r][c]  = (r == c) ? RES_W'(1) : RES_W'(0);
        base[r][c] = (r != c) ? RES_W'(1) : RES_W'(0);
      end
    end
    for (int b = 0; b < EXP_BITS; b++) begin
      if (n[b]) acc = residue_mat_mul(acc, base);
      base = residue_mat_mul(base, base);
    end
    return acc[0][0];
  endfunction

  // mostly short exponents to keep latency down, some full width
  function automatic bit [EXP_BITS-1:0] random_exponent();
    int               bits;
    bit [EXP_BITS-1:0] mask;
    bits = ($urandom_range(99) < 70) ? $urandom_range(1, 10) : EXP_BITS;
    mask = (bits >= EXP_BITS) ? '1 : ((EXP_BITS'(1) << bits) - EXP_BITS'(1));
    return EXP_BITS'($urandom) & mask;
  endfunction

  // append one exponent to the pending words
  task automatic add_exponent(input longint unsigned n);
    exponent_q = {exponent_q, EXP_BITS'(n)};
  endtask

  // driver: predict on acceptance, offer the next word when the slot frees up
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready)
        walk_count_q = {walk_count_q, closed_walks(in_tdata[EXP_BITS-1:0])};
      if (!in_tvalid || in_tready) begin
        if (exponent_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata  <= IN_W'(exponent_q.pop_front());
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // one long receiver hold-off at the start of the last phase so the block backs up
  always @(posedge clk) begin
    if (rst_n) begin
      if (stim_phase == 3 && !hold_done) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
      end
    end
  end

  // monitor: check each accepted word, then decide next cycle's ready
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (walk_count_q.size() == 0) begin
          $error("unexpected word: walk_count actual %0d", out_tdata[RES_W-1:0]);
          fail_cnt++;
        end else begin
          if (out_tdata[RES_W-1:0] !== walk_count_q[0]) begin
            $error("walk_count mismatch: expected %0d, actual %0d",
                   walk_count_q[0], out_tdata[RES_W-1:0]);
            fail_cnt++;
          end
          if (out_tdata[OUT_W-1:RES_W] !== '0) begin
            $error("padding mismatch: expected 0, actual %0d", out_tdata[OUT_W-1:RES_W]);
            fail_cnt++;
          end
          void'(walk_count_q.pop_front());
        end
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // wait until everything queued has gone in and come back
  task automatic wait_drained();
    while (exponent_q.size() != 0 || in_tvalid || walk_count_q.size() != 0)
      @(negedge clk);
  endtask

  // stimulus sequence
  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: zero exponent, small powers, single and alternating bits, extremes
    add_exponent(0);
    add_exponent(1);
    add_exponent(2);
    add_exponent(3);
    add_exponent(4);
    add_exponent(5);
    add_exponent(10);
    add_exponent(31);
    add_exponent(32);
    add_exponent(63);
    add_exponent(64);
    add_exponent(31'h0000_1000);
    add_exponent(31'h4000_0000);
    add_exponent(31'h3FFF_FFFF);
    add_exponent(31'h7FFF_FFFE);
    add_exponent(31'h7FFF_FFFF);
    add_exponent(31'h5555_5555);
    add_exponent(31'h2AAA_AAAA);
    add_exponent(0);
    wait_drained();

    // random phases: sender-light/receiver-heavy idling, swapped, then none
    for (int ph = 1; ph <= 3; ph++) begin
      stim_phase    = ph;
      send_idle_pct = (ph == 1) ? 28 : (ph == 2) ? 51 : 0;
      recv_idle_pct = (ph == 1) ? 51 : (ph == 2) ? 28 : 0;
      for (int i = 0; i < RAND_ITEMS / 3 + 1; i++)
        add_exponent(random_exponent());
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // run limit
  initial begin
    while (cycle_cnt < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("*** FAILED ***");
    $finish;
  end

endmodule
